[sv/sidl_pkg.sv]
// Package for the sync/id/length deframer: phase and result-code enums,
// the result struct and the reset constants. No dependencies.
package sidl_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 16;

  localparam logic [BYTE_W-1:0] SYNC_RESET = 8'h5A;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_ID      = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_LEN_HI  = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    CODE_PAYLOAD = 2'd0,
    CODE_EMPTY   = 2'd1,
    CODE_DISCARD = 2'd2
  } code_t;

  // One result item as produced by the core for the current request.
  typedef struct packed {
    logic              valid;
    code_t             code;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] packet_id;
    logic [LEN_W-1:0]  packet_length;
    logic              last;
  } res_t;

endpackage

[sv/sync_id_length_deframer_unit.sv]
// A result appears on the output in the cycle after its request is taken.
// Throughput: one byte per cycle unless out_tready holds off; the output register
// refills while its current result is taken, so in_tready = !out_tvalid | out_tready.
// Reset (rst_n low, synchronous): hunting for sync, id/length/count cleared,
// sync byte back to 0x5A, output register empty.
module sync_id_length_deframer_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] data_byte, [15:8] packet_id,
                                  // [31:16] packet_length
  output logic [1:0]  out_tuser,  // [1:0] code
  output logic        out_tlast,  // last payload byte or empty packet
  // sync byte register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // [7:0] sync_value
);

  logic                        in_acc;
  logic [sidl_pkg::BYTE_W-1:0] sync_r;
  sidl_pkg::res_t              res;
  sidl_pkg::res_t              out_r;   // payload part of the output register
  logic                        out_vld_r;

  // Config writes must only happen while idle; the block does not enforce this and is always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= sidl_pkg::SYNC_RESET;
    end else if (cfg_valid) begin
      sync_r <= cfg_data;
    end
  end

  // Take a new byte whenever the output slot is free or being drained.
  assign in_tready = !out_vld_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  sidl_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_acc),
    .rx_byte    (in_tdata),
    .sync_value (sync_r),
    .res        (res)
  );

  // Output register. Header bytes give no result and just empty the slot
  // if its result is taken in the same cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (in_acc) begin
      out_vld_r <= res.valid;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res.valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_r.packet_length, out_r.packet_id, out_r.data_byte};
  assign out_tuser  = out_r.code;
  assign out_tlast  = out_r.last;

`ifndef ASSERT_OFF
  // A discarded byte carries no packet tags.
  a_discard_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == sidl_pkg::CODE_DISCARD
      |-> out_tdata[31:8] == '0 && !out_tlast)
    else $error("discard result carries packet tags");

  // An empty packet is always last, with zero length and data.
  a_empty_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == sidl_pkg::CODE_EMPTY
      |-> out_tlast && out_tdata[31:16] == '0 && out_tdata[7:0] == '0)
    else $error("empty packet result malformed");

  // A payload byte never claims a zero-length packet.
  a_payload_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == sidl_pkg::CODE_PAYLOAD |-> out_tdata[31:16] != '0)
    else $error("payload byte with zero packet length");

  // A request that yields no result leaves the output slot empty.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !res.valid |=> !out_tvalid)
    else $error("output valid without a result");
`endif

endmodule

[sv/sidl_core.sv]
// Deframer state machine: header parsing and payload byte counting.
// Depends on sidl_pkg.
module sidl_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [sidl_pkg::BYTE_W-1:0] rx_byte,
  input  logic [sidl_pkg::BYTE_W-1:0] sync_value,
  output sidl_pkg::res_t              res
);

  sidl_pkg::phase_t                phase_r, phase_nxt;
  logic [sidl_pkg::BYTE_W-1:0]     id_r, id_nxt;
  logic [sidl_pkg::LEN_W-1:0]      len_r, len_nxt;
  logic [sidl_pkg::LEN_W-1:0]      left_r, left_nxt;
  logic [sidl_pkg::LEN_W-1:0]      full_len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= sidl_pkg::PH_HUNT;
      id_r    <= '0;
      len_r   <= '0;
      left_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      left_r  <= left_nxt;
    end
  end

  assign full_len = {rx_byte, len_r[sidl_pkg::BYTE_W-1:0]};

  always_comb begin
    phase_nxt = phase_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    left_nxt  = left_r;
    res       = '0;
    unique case (phase_r)
      sidl_pkg::PH_ID: begin
        id_nxt    = rx_byte;
        phase_nxt = sidl_pkg::PH_LEN_LO;
      end
      sidl_pkg::PH_LEN_LO: begin
        len_nxt   = {{(sidl_pkg::LEN_W-sidl_pkg::BYTE_W){1'b0}}, rx_byte};
        phase_nxt = sidl_pkg::PH_LEN_HI;
      end
      sidl_pkg::PH_LEN_HI: begin
        len_nxt = full_len;
        if (full_len == '0) begin
          left_nxt      = '0;
          phase_nxt     = sidl_pkg::PH_HUNT;
          res.valid     = 1'b1;
          res.code      = sidl_pkg::CODE_EMPTY;
          res.packet_id = id_r;
          res.last      = 1'b1;
        end else begin
          left_nxt  = full_len;
          phase_nxt = sidl_pkg::PH_PAYLOAD;
        end
      end
      sidl_pkg::PH_PAYLOAD: begin
        res.valid         = 1'b1;
        res.code          = sidl_pkg::CODE_PAYLOAD;
        res.data_byte     = rx_byte;
        res.packet_id     = id_r;
        res.packet_length = len_r;
        res.last          = (left_r <= sidl_pkg::LEN_W'(1));
        if (res.last) begin
          left_nxt  = '0;
          phase_nxt = sidl_pkg::PH_HUNT;
        end else begin
          left_nxt = left_r - sidl_pkg::LEN_W'(1);
        end
      end
      default: begin
        // hunting, and any phase code that should not occur
        if (rx_byte == sync_value) begin
          phase_nxt = sidl_pkg::PH_ID;
        end else begin
          phase_nxt     = sidl_pkg::PH_HUNT;
          res.valid     = 1'b1;
          res.code      = sidl_pkg::CODE_DISCARD;
          res.data_byte = rx_byte;
        end
      end
    endcase
  end

endmodule

[tb/sync_id_length_deframer_unit_test.sv]
// Self-checking testbench for sync_id_length_deframer_unit: streams bytes in,
// predicts every deframed result in lockstep and checks the result stream.
// Depends on sidl_pkg (code and phase enums, reset sync byte) and the unit.
`timescale 1ns / 100ps

module sync_id_length_deframer_unit_test;

  localparam int STALL_LIMIT = 3000;  // cycles with no handshake at all
  localparam int PHASE_ITEMS = 210;   // bytes per sync setting in the random test

  // Receiver stall styles.
  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_style_t;

  // One expected result, fields in the order the checker compares them.
  typedef struct packed {
    sidl_pkg::code_t code;
    logic [7:0]      data_b;
    logic [7:0]      pid;
    logic [15:0]     plen;
    logic            is_last;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;  // [7:0] data_byte, [15:8] packet_id, [31:16] packet_length
  logic [1:0]  out_tuser;  // [1:0] code
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;   // [7:0] sync_value

  sync_id_length_deframer_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Deframer state as the testbench tracks it
  // ---------------------------------------------------------------------------
  sidl_pkg::phase_t st_phase;
  logic [7:0]       st_sync;
  logic [7:0]       st_id;
  logic [15:0]      st_len;
  logic [15:0]      st_left;

  frame_result_t pending_q[$];   // results owed by the unit, oldest first

  logic [7:0] sync_now;          // sync byte the stimulus builds packets with
  int mismatches    = 0;
  int bytes_in      = 0;
  int n_payload     = 0;
  int n_empty       = 0;
  int n_discard     = 0;
  int n_sync_writes = 0;
  int stall_cycles  = 0;

  // Sender burst state and receiver style, shared with the driver processes.
  int        burst_left = 0;
  bit        gaps_on    = 1'b0;
  rx_style_t rx_style   = RX_ALWAYS;
  int        rx_hold    = 0;
  int        rx_cyc     = 0;

  // Advance the deframer by one accepted byte and queue what it owes.
  function automatic void deframe_byte(input logic [7:0] b);
    frame_result_t r;
    case (st_phase)
      sidl_pkg::PH_ID: begin
        st_id    = b;
        st_phase = sidl_pkg::PH_LEN_LO;
      end
      sidl_pkg::PH_LEN_LO: begin
        st_len   = {8'h00, b};
        st_phase = sidl_pkg::PH_LEN_HI;
      end
      sidl_pkg::PH_LEN_HI: begin
        st_len = {b, st_len[7:0]};
        if (st_len == 16'h0000) begin
          // zero length: one empty-packet marker, back to hunting
          st_left  = 16'h0000;
          st_phase = sidl_pkg::PH_HUNT;
          r = '{sidl_pkg::CODE_EMPTY, 8'h00, st_id, 16'h0000, 1'b1};
          pending_q.push_back(r);
        end else begin
          st_left  = st_len;
          st_phase = sidl_pkg::PH_PAYLOAD;
        end
      end
      sidl_pkg::PH_PAYLOAD: begin
        r = '{sidl_pkg::CODE_PAYLOAD, b, st_id, st_len, (st_left <= 16'd1)};
        pending_q.push_back(r);
        if (st_left <= 16'd1) begin
          st_left  = 16'h0000;
          st_phase = sidl_pkg::PH_HUNT;
        end else begin
          st_left = st_left - 16'd1;
        end
      end
      default: begin
        // hunting; any stray phase code behaves the same way
        st_phase = sidl_pkg::PH_HUNT;
        if (b == st_sync) begin
          st_phase = sidl_pkg::PH_ID;
        end else begin
          r = '{sidl_pkg::CODE_DISCARD, b, 8'h00, 16'h0000, 1'b0};
          pending_q.push_back(r);
        end
      end
    endcase
  endfunction

  function automatic void check_field(input string what, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, what, want, got);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: results are checked before new requests are predicted, so a
  // spurious output cannot be matched against an expectation queued this edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    frame_result_t e;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_q.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual code %0d data 0x%0h",
                   $time, out_tuser, out_tdata);
          mismatches++;
        end else begin
          e = pending_q.pop_front();
          check_field("code", 16'(e.code), 16'(out_tuser));
          check_field("data_byte", 16'(e.data_b), 16'(out_tdata[7:0]));
          check_field("packet_id", 16'(e.pid), 16'(out_tdata[15:8]));
          check_field("packet_length", e.plen, out_tdata[31:16]);
          check_field("last", 16'(e.is_last), 16'(out_tlast));
          case (e.code)
            sidl_pkg::CODE_PAYLOAD: n_payload++;
            sidl_pkg::CODE_EMPTY:   n_empty++;
            default:                n_discard++;
          endcase
        end
      end
      if (cfg_valid && cfg_ready)
        st_sync = cfg_data;
      if (in_tvalid && in_tready) begin
        bytes_in++;
        deframe_byte(in_tdata);
      end
    end
  end

  // Watchdog: a run that stops moving ends here.
  always @(posedge clk) begin
    if (rst_n && ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
                  (cfg_valid && cfg_ready)))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no handshake for %0d cycles, %0d results outstanding",
               $time, stall_cycles, pending_q.size());
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: a long hold-off takes priority, otherwise the current style.
  always @(negedge clk) begin
    rx_cyc++;
    if (rx_hold > 0) begin
      out_tready = 1'b0;
      rx_hold--;
    end else begin
      case (rx_style)
        RX_ALWAYS: out_tready = 1'b1;
        RX_RANDOM: out_tready = ($urandom_range(0, 3) != 0);
        default:   out_tready = ((rx_cyc % 9) > 2);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Shared driver tasks
  // ---------------------------------------------------------------------------

  // Offer one byte; bursts of random length, separated by random gaps when gaps are on.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    burst_left--;
    in_tvalid = 1'b1;
    in_tdata  = b;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic send_packet(input logic [7:0] pid, input logic [15:0] plen);
    send_byte(sync_now);
    send_byte(pid);
    send_byte(plen[7:0]);
    send_byte(plen[15:8]);
    for (int i = 0; i < plen; i++)
      send_byte(8'($urandom_range(0, 255)));
  endtask

  // Sender pauses until every owed result has come back.
  task automatic wait_results();
    while (pending_q.size() != 0) @(negedge clk);
  endtask

  // Sync byte write, only with the unit idle; header bytes leave no result,
  // so after the queue drains the task also waits past the output register.
  task automatic write_sync(input logic [7:0] v);
    wait_results();
    repeat (3) @(negedge clk);
    cfg_data  = v;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    sync_now  = v;
    n_sync_writes++;
  endtask

  task automatic set_traffic(input rx_style_t style, input bit gaps);
    rx_style   = style;
    gaps_on    = gaps;
    burst_left = 0;
  endtask

  // Random byte that is not the current sync byte.
  function automatic logic [7:0] stray_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == sync_now)
      b = ~b;
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset sync byte: discards at both byte extremes, a packet with id 0xFF and
  // sync-valued payload, an empty packet, and sync bytes in header and payload.
  task automatic test_directed_bytes();
    set_traffic(RX_ALWAYS, 1'b0);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(sync_now);
    send_byte(8'hFF);
    send_byte(8'h02);
    send_byte(8'h00);
    send_byte(sync_now);
    send_byte(8'hFF);
    send_byte(sync_now);           // empty packet, id 0
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(sync_now);           // sync as id and as the only payload byte
    send_byte(sync_now);
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(sync_now);
    wait_results();
  endtask

  // Sync register at both extremes, then back to its reset value.
  task automatic test_sync_register();
    logic [7:0] vals [3];
    vals = '{8'h00, 8'hFF, sidl_pkg::SYNC_RESET};
    foreach (vals[k]) begin
      write_sync(vals[k]);
      set_traffic(RX_RANDOM, 1'b1);
      send_byte(stray_byte());
      send_byte(8'(vals[k] + 8'd1));
      send_packet(8'(k), 16'd3);
      send_packet(8'hA5, 16'd0);
      send_byte(stray_byte());
    end
    wait_results();
  endtask

  // Receiver holds off while discards keep coming, so the output register
  // fills and the input stalls; then the sender waits for a full drain.
  task automatic test_backpressure();
    set_traffic(RX_ALWAYS, 1'b0);
    rx_hold = 150;
    repeat (12) send_byte(stray_byte());
    send_packet(8'h3C, 16'd5);
    wait_results();
  endtask

  // Lengths with a zero low byte and with a full low byte.
  task automatic test_long_packets();
    set_traffic(RX_RANDOM, 1'b0);
    send_packet(8'h81, 16'h0100);
    send_packet(8'h7E, 16'h00FF);
    wait_results();
  endtask

  // Mostly well-formed packets with random content, some stray bytes and
  // truncated headers, over several sync settings and traffic styles.
  task automatic test_random_traffic();
    int start;
    int r;
    logic [15:0] plen;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       write_sync(8'h00);
        1:       write_sync(8'hFF);
        5:       write_sync(sidl_pkg::SYNC_RESET);
        default: write_sync(8'($urandom_range(0, 255)));
      endcase
      set_traffic(rx_style_t'(p % 3), (p != 3));
      start = bytes_in;
      while (bytes_in - start < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          r = $urandom_range(0, 99);
          if (r < 10)      plen = 16'd0;
          else if (r < 75) plen = 16'($urandom_range(1, 6));
          else if (r < 98) plen = 16'($urandom_range(7, 40));
          else             plen = {8'h01, 8'($urandom_range(0, 15))};
          send_packet(8'($urandom_range(0, 255)), plen);
        end else if (r < 92) begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end else begin
          // header cut short; the next bytes are taken as its remainder
          send_byte(sync_now);
          repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
        end
      end
    end
    wait_results();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    cfg_valid = 1'b0;
    cfg_data  = 8'h00;
    sync_now  = sidl_pkg::SYNC_RESET;
    st_phase  = sidl_pkg::PH_HUNT;
    st_sync   = sidl_pkg::SYNC_RESET;
    st_id     = 8'h00;
    st_len    = 16'h0000;
    st_left   = 16'h0000;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    test_directed_bytes();
    test_sync_register();
    test_backpressure();
    test_long_packets();
    test_random_traffic();

    wait_results();
    repeat (5) @(posedge clk);
    $display("Ran %0d bytes through %0d sync settings: %0d payload bytes,",
             bytes_in, n_sync_writes, n_payload);
    $display("%0d empty packets and %0d stray bytes; %0d field mismatches.",
             n_empty, n_discard, mismatches);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
